// ===== rtl/osc_pkg.sv =====
// shared types and constants for the offset sprite tile compositor
package osc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TILE_COLS = 8;
    localparam int unsigned TILE_W = BYTE_W * TILE_COLS;

    localparam logic [7:0] COL_START_BASE = 8'd120;
    localparam logic [7:0] COL_END_BASE = 8'd127;

    typedef logic [TILE_W-1:0] tile_t;

    // write order within one request
    typedef enum logic [1:0] {
        QUAD_TL = 2'd0,
        QUAD_TR = 2'd1,
        QUAD_BL = 2'd2,
        QUAD_BR = 2'd3
    } quad_t;

    typedef struct packed {
        tile_t tl;
        tile_t tr;
        tile_t bl;
        tile_t br;
    } quad_tiles_t;

endpackage

// ===== rtl/osc_blend.sv =====
// mirrors, shifts and ORs the sprite into the four background tiles
module osc_blend
    import osc_pkg::*;
(
    input  logic [2:0]  off_x,
    input  logic [2:0]  off_y,
    input  tile_t       sprite,
    input  quad_tiles_t bg,
    output quad_tiles_t result
);

    genvar j;
    generate
        for (j = 0; j < TILE_COLS; j++)
        begin : g_col
            logic        left;
            logic [2:0]  src;
            logic [7:0]  src_byte;
            logic [15:0] shifted;
            logic [7:0]  up;
            logic [7:0]  down;

            assign left = (3'(j) >= off_x);
            // mirrored source column, mod 8 arithmetic
            assign src = left ? (3'd7 - (3'(j) - off_x)) : (off_x - 3'(j) - 3'd1);
            assign src_byte = sprite[src*BYTE_W +: BYTE_W];
            // low byte lands in the top tile, bits pushed out land in the bottom one
            assign shifted = {8'h00, src_byte} << off_y;
            assign up = shifted[7:0];
            assign down = shifted[15:8];

            assign result.tl[j*BYTE_W +: BYTE_W] = bg.tl[j*BYTE_W +: BYTE_W] | (left ? up : 8'h00);
            assign result.tr[j*BYTE_W +: BYTE_W] = bg.tr[j*BYTE_W +: BYTE_W] | (left ? 8'h00 : up);
            assign result.bl[j*BYTE_W +: BYTE_W] = bg.bl[j*BYTE_W +: BYTE_W] | (left ? down : 8'h00);
            assign result.br[j*BYTE_W +: BYTE_W] = bg.br[j*BYTE_W +: BYTE_W] | (left ? 8'h00 : down);
        end
    endgenerate

endmodule

// ===== rtl/offset_sprite_tile_compositor.sv =====
// top level: input register, compositing, tile bank and write sequencer
// a request passes through the input register and the tile bank before the result register shows its first tile write
// the four writes follow on consecutive cycles, top-left first, bottom-right last
// the single result port bounds the request rate, as each request takes four writes; the receiver cannot stall
// a new request is taken while the previous one is still being written out
// reset clears all valid flags and the strobe; payload registers are not reset
module offset_sprite_tile_compositor
    import osc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [6:0]  pos_x,
    input  logic [5:0]  pos_y,
    input  logic [63:0] sprite_bits,
    input  logic [63:0] bg_top_left,
    input  logic [63:0] bg_top_right,
    input  logic [63:0] bg_bottom_left,
    input  logic [63:0] bg_bottom_right,
    output logic        strobe,
    output logic [4:0]  tile_column,
    output logic [3:0]  tile_row,
    output logic [7:0]  column_start,
    output logic [7:0]  column_end,
    output logic [3:0]  page_end,
    output logic [63:0] tile_bits,
    output logic        last_write
);

    // input register
    logic        in_valid_reg;
    logic [6:0]  pos_x_reg;
    logic [5:0]  pos_y_reg;
    tile_t       sprite_reg;
    quad_tiles_t bg_reg;

    // tile bank
    logic        bank_valid_reg;
    logic [1:0]  cnt_reg;
    logic [3:0]  tx_reg;
    logic [2:0]  ty_reg;
    quad_tiles_t bank_reg;

    // result register
    logic        strobe_reg;
    logic [4:0]  col_reg;
    logic [3:0]  row_reg;
    logic [7:0]  col_start_reg;
    logic [7:0]  col_end_reg;
    logic [3:0]  page_end_reg;
    tile_t       bits_reg;
    logic        last_reg;

    quad_tiles_t blended;
    logic        accept;
    logic        bank_done;
    logic        bank_load;
    logic        right;
    logic        bottom;
    logic [4:0]  col_next;
    logic [3:0]  row_next;
    logic [7:0]  col_px;
    tile_t       bits_next;

    assign bank_done = bank_valid_reg && (cnt_reg == QUAD_BR);
    assign bank_load = in_valid_reg && (!bank_valid_reg || bank_done);
    assign busy      = in_valid_reg && !bank_load;
    assign accept    = start && !busy;

    osc_blend u_blend (
        .off_x  (pos_x_reg[2:0]),
        .off_y  (pos_y_reg[2:0]),
        .sprite (sprite_reg),
        .bg     (bg_reg),
        .result (blended)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept || (in_valid_reg && !bank_load);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_x_reg  <= pos_x;
            pos_y_reg  <= pos_y;
            sprite_reg <= sprite_bits;
            bg_reg     <= '{tl: bg_top_left, tr: bg_top_right,
                            bl: bg_bottom_left, br: bg_bottom_right};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_valid_reg <= 1'b0;
            cnt_reg        <= QUAD_TL;
        end
        else
        begin
            if (bank_load)
            begin
                bank_valid_reg <= 1'b1;
                cnt_reg        <= QUAD_TL;
            end
            else if (bank_valid_reg)
            begin
                bank_valid_reg <= !bank_done;
                cnt_reg        <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bank_load)
        begin
            tx_reg   <= pos_x_reg[6:3];
            ty_reg   <= pos_y_reg[5:3];
            bank_reg <= blended;
        end
    end

    // cnt bit 0 picks the right tiles, bit 1 the bottom tiles
    assign right    = cnt_reg[0];
    assign bottom   = cnt_reg[1];
    assign col_next = {1'b0, tx_reg} + {4'd0, right};
    assign row_next = {1'b0, ty_reg} + {3'd0, bottom};
    assign col_px   = {col_next, 3'b000};

    always_comb
    begin
        case (cnt_reg)
            QUAD_TL: bits_next = bank_reg.tl;
            QUAD_TR: bits_next = bank_reg.tr;
            QUAD_BL: bits_next = bank_reg.bl;
            default: bits_next = bank_reg.br;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= bank_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bank_valid_reg)
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            col_start_reg <= COL_START_BASE - col_px;
            col_end_reg   <= COL_END_BASE - col_px;
            page_end_reg  <= row_next + 4'd1;
            bits_reg      <= bits_next;
            last_reg      <= (cnt_reg == QUAD_BR);
        end
    end

    assign strobe       = strobe_reg;
    assign tile_column  = col_reg;
    assign tile_row     = row_reg;
    assign column_start = col_start_reg;
    assign column_end   = col_end_reg;
    assign page_end     = page_end_reg;
    assign tile_bits    = bits_reg;
    assign last_write   = strobe_reg && last_reg;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_valid_reg)
        else $error("accepted request not held in input register");

    a_bank_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_valid_reg && cnt_reg != QUAD_BR) |=> (bank_valid_reg && strobe_reg))
        else $error("tile bank dropped before its last write");

    a_burst_of_four: assert property (@(posedge clk) disable iff (!rst_n)
        last_write |-> ($past(strobe_reg, 1) && $past(strobe_reg, 2) && $past(strobe_reg, 3)))
        else $error("last write not preceded by three writes");

    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |=> strobe_reg)
        else $error("gap inside a four write burst");

endmodule
